// ===== hw/rtl/h261rl_pkg.sv =====
// shared types, constants and the tcoeff code table of the run-level coder
// no dependencies
package h261rl_pkg;

  localparam int CoefW       = 12;
  localparam int PosW        = 6;
  localparam int QuantW      = 5;
  localparam int ThrW        = 3;
  localparam int CodeW       = 20;
  localparam int LenW        = 5;
  localparam int RunW        = 6;
  localparam int LevW        = 8;
  localparam int DivSteps    = CoefW;
  localparam int StepW       = $clog2(DivSteps);
  localparam int FifoDepth   = 2;
  localparam int FifoPtrW    = $clog2(FifoDepth);
  localparam int FifoCntW    = $clog2(FifoDepth + 1);

  localparam logic [PosW-1:0] FilterStart = PosW'(20);
  localparam logic [PosW-1:0] LastPos     = PosW'(63);
  localparam logic [LenW-1:0] DcLen       = LenW'(8);
  localparam logic [LenW-1:0] EscLen      = LenW'(20);
  localparam logic [LenW-1:0] EobLen      = LenW'(2);
  localparam logic [CodeW-1:0] EobCode    = CodeW'(2);
  localparam logic [5:0]       EscPrefix  = 6'b000001;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  // one classified term handed from the front to the back
  typedef struct packed {
    logic            is_dc;
    logic            last;
    logic [LevW-1:0] val;
  } term_t;

  typedef struct packed {
    logic       found;
    logic [5:0] bits;
    logic [3:0] len;
  } vlc_t;

  function automatic vlc_t tcoeff_lookup(input logic [RunW-1:0] run, input logic [3:0] lev);
    vlc_t v;
    v = '{found: 1'b1, bits: 6'h00, len: 4'd0};
    case ({run, lev})
      {6'd0, 4'd1}:   begin v.bits = 6'h03; v.len = 4'd2;  end
      {6'd0, 4'd2}:   begin v.bits = 6'h04; v.len = 4'd4;  end
      {6'd0, 4'd3}:   begin v.bits = 6'h05; v.len = 4'd5;  end
      {6'd0, 4'd4}:   begin v.bits = 6'h06; v.len = 4'd7;  end
      {6'd0, 4'd5}:   begin v.bits = 6'h26; v.len = 4'd8;  end
      {6'd0, 4'd6}:   begin v.bits = 6'h21; v.len = 4'd8;  end
      {6'd0, 4'd7}:   begin v.bits = 6'h0A; v.len = 4'd10; end
      {6'd0, 4'd8}:   begin v.bits = 6'h1D; v.len = 4'd12; end
      {6'd0, 4'd9}:   begin v.bits = 6'h18; v.len = 4'd12; end
      {6'd0, 4'd10}:  begin v.bits = 6'h13; v.len = 4'd12; end
      {6'd0, 4'd11}:  begin v.bits = 6'h10; v.len = 4'd12; end
      {6'd0, 4'd12}:  begin v.bits = 6'h1A; v.len = 4'd13; end
      {6'd0, 4'd13}:  begin v.bits = 6'h19; v.len = 4'd13; end
      {6'd0, 4'd14}:  begin v.bits = 6'h18; v.len = 4'd13; end
      {6'd0, 4'd15}:  begin v.bits = 6'h17; v.len = 4'd13; end
      {6'd1, 4'd1}:   begin v.bits = 6'h03; v.len = 4'd3;  end
      {6'd1, 4'd2}:   begin v.bits = 6'h06; v.len = 4'd6;  end
      {6'd1, 4'd3}:   begin v.bits = 6'h25; v.len = 4'd8;  end
      {6'd1, 4'd4}:   begin v.bits = 6'h0C; v.len = 4'd10; end
      {6'd1, 4'd5}:   begin v.bits = 6'h1B; v.len = 4'd12; end
      {6'd1, 4'd6}:   begin v.bits = 6'h16; v.len = 4'd13; end
      {6'd1, 4'd7}:   begin v.bits = 6'h15; v.len = 4'd13; end
      {6'd2, 4'd1}:   begin v.bits = 6'h05; v.len = 4'd4;  end
      {6'd2, 4'd2}:   begin v.bits = 6'h04; v.len = 4'd7;  end
      {6'd2, 4'd3}:   begin v.bits = 6'h0B; v.len = 4'd10; end
      {6'd2, 4'd4}:   begin v.bits = 6'h14; v.len = 4'd12; end
      {6'd2, 4'd5}:   begin v.bits = 6'h14; v.len = 4'd13; end
      {6'd3, 4'd1}:   begin v.bits = 6'h07; v.len = 4'd5;  end
      {6'd3, 4'd2}:   begin v.bits = 6'h24; v.len = 4'd8;  end
      {6'd3, 4'd3}:   begin v.bits = 6'h1C; v.len = 4'd12; end
      {6'd3, 4'd4}:   begin v.bits = 6'h13; v.len = 4'd13; end
      {6'd4, 4'd1}:   begin v.bits = 6'h06; v.len = 4'd5;  end
      {6'd4, 4'd2}:   begin v.bits = 6'h0F; v.len = 4'd10; end
      {6'd4, 4'd3}:   begin v.bits = 6'h12; v.len = 4'd12; end
      {6'd5, 4'd1}:   begin v.bits = 6'h07; v.len = 4'd6;  end
      {6'd5, 4'd2}:   begin v.bits = 6'h09; v.len = 4'd10; end
      {6'd5, 4'd3}:   begin v.bits = 6'h12; v.len = 4'd13; end
      {6'd6, 4'd1}:   begin v.bits = 6'h05; v.len = 4'd6;  end
      {6'd6, 4'd2}:   begin v.bits = 6'h1E; v.len = 4'd12; end
      {6'd7, 4'd1}:   begin v.bits = 6'h04; v.len = 4'd6;  end
      {6'd7, 4'd2}:   begin v.bits = 6'h15; v.len = 4'd12; end
      {6'd8, 4'd1}:   begin v.bits = 6'h07; v.len = 4'd7;  end
      {6'd8, 4'd2}:   begin v.bits = 6'h11; v.len = 4'd12; end
      {6'd9, 4'd1}:   begin v.bits = 6'h05; v.len = 4'd7;  end
      {6'd9, 4'd2}:   begin v.bits = 6'h11; v.len = 4'd13; end
      {6'd10, 4'd1}:  begin v.bits = 6'h27; v.len = 4'd8;  end
      {6'd10, 4'd2}:  begin v.bits = 6'h10; v.len = 4'd13; end
      {6'd11, 4'd1}:  begin v.bits = 6'h23; v.len = 4'd8;  end
      {6'd12, 4'd1}:  begin v.bits = 6'h22; v.len = 4'd8;  end
      {6'd13, 4'd1}:  begin v.bits = 6'h20; v.len = 4'd8;  end
      {6'd14, 4'd1}:  begin v.bits = 6'h0E; v.len = 4'd10; end
      {6'd15, 4'd1}:  begin v.bits = 6'h0D; v.len = 4'd10; end
      {6'd16, 4'd1}:  begin v.bits = 6'h08; v.len = 4'd10; end
      {6'd17, 4'd1}:  begin v.bits = 6'h1F; v.len = 4'd12; end
      {6'd18, 4'd1}:  begin v.bits = 6'h1A; v.len = 4'd12; end
      {6'd19, 4'd1}:  begin v.bits = 6'h19; v.len = 4'd12; end
      {6'd20, 4'd1}:  begin v.bits = 6'h17; v.len = 4'd12; end
      {6'd21, 4'd1}:  begin v.bits = 6'h16; v.len = 4'd12; end
      {6'd22, 4'd1}:  begin v.bits = 6'h1F; v.len = 4'd13; end
      {6'd23, 4'd1}:  begin v.bits = 6'h1E; v.len = 4'd13; end
      {6'd24, 4'd1}:  begin v.bits = 6'h1D; v.len = 4'd13; end
      {6'd25, 4'd1}:  begin v.bits = 6'h1C; v.len = 4'd13; end
      {6'd26, 4'd1}:  begin v.bits = 6'h1B; v.len = 4'd13; end
      default:        v.found = 1'b0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/h261rl_front.sv =====
// front end: accepts coefficients, rounds dc terms, scales and filters ac terms
// uses h261rl_pkg; holds the divide_enable register and a bit-serial divider
module h261rl_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [h261rl_pkg::CoefW-1:0]   in_coefficient,
  input  logic [h261rl_pkg::PosW-1:0]    in_scan_position,
  input  logic [h261rl_pkg::QuantW-1:0]  in_quantizer,
  input  logic [h261rl_pkg::ThrW-1:0]    in_filter_threshold,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_divide_enable,
  output logic                           push,
  output h261rl_pkg::term_t              push_term,
  input  logic                           fifo_full
);

  h261rl_pkg::front_state_t state_r, state_nxt;

  logic                            div_en_r;
  logic                            neg_r;
  logic [h261rl_pkg::PosW-1:0]     pos_r;
  logic [h261rl_pkg::ThrW-1:0]     thr_r;
  logic [h261rl_pkg::QuantW-1:0]   q_r;
  logic [h261rl_pkg::CoefW-1:0]    quo_r, quo_nxt;
  logic [5:0]                      rem_r, rem_nxt;
  logic [h261rl_pkg::StepW-1:0]    cnt_r;
  logic [7:0]                      dc_r;

  logic                            accept;
  logic                            in_neg;
  logic [h261rl_pkg::CoefW-1:0]    in_mag;
  logic                            skip_div;
  logic signed [12:0]              dc_sum;
  logic signed [9:0]               dc_shr;
  logic [7:0]                      dc_val;
  logic [6:0]                      div_sh;
  logic [6:0]                      div_d;
  logic                            div_ge;
  logic                            div_done;
  logic                            filt_zero;
  logic [7:0]                      lev8;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_neg    = in_coefficient[h261rl_pkg::CoefW-1];
  assign in_mag    = in_neg ? (~in_coefficient + 1'b1) : in_coefficient;
  assign skip_div  = (in_scan_position == '0) || !div_en_r || (in_quantizer == '0);

  // dc rounding: (c + 4) >> 3, then clamp to 1..254, with 128 sent as 255
  assign dc_sum = {in_coefficient[h261rl_pkg::CoefW-1], in_coefficient} + 13'sd4;
  assign dc_shr = 10'(dc_sum >>> 3);
  always_comb begin
    if (dc_shr <= 10'sd0) begin
      dc_val = 8'd1;
    end else if (dc_shr > 10'sd254) begin
      dc_val = 8'd254;
    end else if (dc_shr == 10'sd128) begin
      dc_val = 8'd255;
    end else begin
      dc_val = dc_shr[7:0];
    end
  end

  // restoring divider, one quotient bit per cycle, quotient shifts into quo_r
  assign div_d    = {1'b0, q_r, 1'b0};
  assign div_sh   = {rem_r, quo_r[h261rl_pkg::CoefW-1]};
  assign div_ge   = div_sh >= div_d;
  assign rem_nxt  = div_ge ? 6'(div_sh - div_d) : div_sh[5:0];
  assign quo_nxt  = {quo_r[h261rl_pkg::CoefW-2:0], div_ge};
  assign div_done = (cnt_r == h261rl_pkg::StepW'(h261rl_pkg::DivSteps - 1));

  assign filt_zero = (pos_r >= h261rl_pkg::FilterStart) &&
                     (quo_r <= h261rl_pkg::CoefW'(thr_r));
  assign lev8      = filt_zero ? 8'd0 : (neg_r ? (8'd0 - quo_r[7:0]) : quo_r[7:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      h261rl_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = skip_div ? h261rl_pkg::F_PUSH : h261rl_pkg::F_DIV;
        end
      end
      h261rl_pkg::F_DIV: begin
        if (div_done) begin
          state_nxt = h261rl_pkg::F_PUSH;
        end
      end
      h261rl_pkg::F_PUSH: begin
        if (!fifo_full) begin
          state_nxt = h261rl_pkg::F_IDLE;
        end
      end
      default: state_nxt = h261rl_pkg::F_IDLE;
    endcase
  end

  assign in_stall        = (state_r != h261rl_pkg::F_IDLE);
  assign push            = (state_r == h261rl_pkg::F_PUSH) && !fifo_full;
  assign push_term.is_dc = (pos_r == '0);
  assign push_term.last  = (pos_r == h261rl_pkg::LastPos);
  assign push_term.val   = (pos_r == '0) ? dc_r : lev8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= h261rl_pkg::F_IDLE;
      div_en_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        div_en_r <= cfg_divide_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= in_neg;
      pos_r <= in_scan_position;
      thr_r <= in_filter_threshold;
      q_r   <= in_quantizer;
      quo_r <= in_mag;
      rem_r <= '0;
      cnt_r <= '0;
      dc_r  <= dc_val;
    end else if (state_r == h261rl_pkg::F_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/h261rl_fifo.sv =====
// two-word queue of classified terms between front and back
// uses h261rl_pkg
module h261rl_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  h261rl_pkg::term_t push_term,
  output logic              full,
  input  logic              pop,
  output h261rl_pkg::term_t pop_term,
  output logic              empty
);

  h261rl_pkg::term_t                  mem_r [h261rl_pkg::FifoDepth];
  logic [h261rl_pkg::FifoPtrW-1:0]    wr_r, rd_r;
  logic [h261rl_pkg::FifoCntW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == h261rl_pkg::FifoCntW'(h261rl_pkg::FifoDepth));
  assign empty    = (cnt_r == '0);
  assign pop_term = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_term;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= h261rl_pkg::FifoCntW'(h261rl_pkg::FifoDepth))
    else $error("queue count out of range");

endmodule

// ===== hw/rtl/h261rl_back.sv =====
// back end: keeps the zero run and turns terms into dc, tcoeff, escape and eob codes
// uses h261rl_pkg; output word held in a register
module h261rl_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fifo_empty,
  input  h261rl_pkg::term_t             pop_term,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [h261rl_pkg::CodeW-1:0]  out_code_bits,
  output logic [h261rl_pkg::LenW-1:0]   out_code_length,
  output logic                          out_block_end
);

  logic [h261rl_pkg::RunW-1:0]   run_r, run_nxt;
  logic                          eob_pend_r, eob_pend_nxt;
  logic                          ov_r, ov_nxt;
  logic [h261rl_pkg::CodeW-1:0]  bits_r, bits_nxt;
  logic [h261rl_pkg::LenW-1:0]   len_r, len_nxt;
  logic                          end_r, end_nxt;

  logic                          slot;
  logic                          lneg;
  logic [7:0]                    amag;
  h261rl_pkg::vlc_t              vlc;

  assign slot = !ov_r || !out_stall;
  assign pop  = slot && !eob_pend_r && !fifo_empty;
  assign lneg = pop_term.val[7];
  assign amag = lneg ? (8'd0 - pop_term.val) : pop_term.val;
  assign vlc  = h261rl_pkg::tcoeff_lookup(run_r, amag[3:0]);

  always_comb begin
    run_nxt      = run_r;
    eob_pend_nxt = eob_pend_r;
    ov_nxt       = ov_r && out_stall;
    bits_nxt     = bits_r;
    len_nxt      = len_r;
    end_nxt      = end_r;
    if (slot && eob_pend_r) begin
      ov_nxt       = 1'b1;
      bits_nxt     = h261rl_pkg::EobCode;
      len_nxt      = h261rl_pkg::EobLen;
      end_nxt      = 1'b1;
      eob_pend_nxt = 1'b0;
    end else if (pop) begin
      if (pop_term.is_dc) begin
        ov_nxt   = 1'b1;
        bits_nxt = h261rl_pkg::CodeW'(pop_term.val);
        len_nxt  = h261rl_pkg::DcLen;
        end_nxt  = 1'b0;
        run_nxt  = '0;
      end else if (pop_term.val == '0) begin
        // zero level only lengthens the run, unless it closes the block
        if (pop_term.last) begin
          ov_nxt   = 1'b1;
          bits_nxt = h261rl_pkg::EobCode;
          len_nxt  = h261rl_pkg::EobLen;
          end_nxt  = 1'b1;
          run_nxt  = '0;
        end else begin
          run_nxt = run_r + 1'b1;
        end
      end else begin
        ov_nxt  = 1'b1;
        end_nxt = 1'b0;
        if ((amag <= 8'd15) && vlc.found) begin
          bits_nxt = h261rl_pkg::CodeW'({vlc.bits, lneg});
          len_nxt  = h261rl_pkg::LenW'(vlc.len) + 1'b1;
        end else begin
          bits_nxt = {h261rl_pkg::EscPrefix, run_r, pop_term.val};
          len_nxt  = h261rl_pkg::EscLen;
        end
        run_nxt      = '0;
        eob_pend_nxt = pop_term.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= '0;
      eob_pend_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      run_r      <= run_nxt;
      eob_pend_r <= eob_pend_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    len_r  <= len_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid       = ov_r;
  assign out_code_bits   = bits_r;
  assign out_code_length = len_r;
  assign out_block_end   = end_r;

endmodule

// ===== hw/rtl/h261_block_run_level_coder_top.sv =====
// with no division (dc terms, divide off or quantizer 0) a coefficient is registered in
// the front, pushed to the queue and coded into the output register; with division the
// front first runs the 12-step bit-serial divider; it stalls until each term is pushed.
// the back sends one code word per cycle when fed and not stalled; an ac term with eob gives two words
// reset: synchronous active-low rst_n clears the zero run, the queue and the output
// valid, and sets divide_enable to 1
module h261_block_run_level_coder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [h261rl_pkg::CoefW-1:0]   in_coefficient,
  input  logic [h261rl_pkg::PosW-1:0]    in_scan_position,
  input  logic [h261rl_pkg::QuantW-1:0]  in_quantizer,
  input  logic [h261rl_pkg::ThrW-1:0]    in_filter_threshold,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_divide_enable,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [h261rl_pkg::CodeW-1:0]   out_code_bits,
  output logic [h261rl_pkg::LenW-1:0]    out_code_length,
  output logic                           out_block_end
);

  logic              push, pop, full, empty;
  h261rl_pkg::term_t push_term, pop_term;

  h261rl_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_coefficient      (in_coefficient),
    .in_scan_position    (in_scan_position),
    .in_quantizer        (in_quantizer),
    .in_filter_threshold (in_filter_threshold),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_divide_enable   (cfg_divide_enable),
    .push                (push),
    .push_term           (push_term),
    .fifo_full           (full)
  );

  h261rl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_term (push_term),
    .full      (full),
    .pop       (pop),
    .pop_term  (pop_term),
    .empty     (empty)
  );

  h261rl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_empty      (empty),
    .pop_term        (pop_term),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_bits   (out_code_bits),
    .out_code_length (out_code_length),
    .out_block_end   (out_block_end)
  );

endmodule

// ===== verif/h261rl_checker.sv =====
// checker for the run-level coder: watches the coefficient and code channels,
// predicts the code words and compares them; depends on h261rl_pkg only for widths
`timescale 1ns / 1ps
module h261rl_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [h261rl_pkg::CoefW-1:0]  in_coefficient,
  input  logic [h261rl_pkg::PosW-1:0]   in_scan_position,
  input  logic [h261rl_pkg::QuantW-1:0] in_quantizer,
  input  logic [h261rl_pkg::ThrW-1:0]   in_filter_threshold,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_divide_enable,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [h261rl_pkg::CodeW-1:0]  out_code_bits,
  input  logic [h261rl_pkg::LenW-1:0]   out_code_length,
  input  logic                          out_block_end,
  output int                            fail_count,
  output int                            pending_words,
  output int                            words_seen,
  output int                            blocks_seen
);
  typedef struct packed {
    logic [19:0] bits;
    logic [4:0]  len;
    logic        eob;
  } code_word_t;

  code_word_t word_q[$];
  logic       div_on;
  logic [5:0] run_len;

  // h261 tcoeff table: returns length 0 when (run, level) has no short code
  function automatic void tcoeff_code(input int run, input int lev, output int bits,
                                      output int len);
    int tab[63][4];
    tab = '{
      '{0,1,'h03,2}, '{0,2,'h04,4}, '{0,3,'h05,5}, '{0,4,'h06,7},
      '{0,5,'h26,8}, '{0,6,'h21,8}, '{0,7,'h0A,10}, '{0,8,'h1D,12},
      '{0,9,'h18,12}, '{0,10,'h13,12}, '{0,11,'h10,12}, '{0,12,'h1A,13},
      '{0,13,'h19,13}, '{0,14,'h18,13}, '{0,15,'h17,13},
      '{1,1,'h03,3}, '{1,2,'h06,6}, '{1,3,'h25,8}, '{1,4,'h0C,10},
      '{1,5,'h1B,12}, '{1,6,'h16,13}, '{1,7,'h15,13},
      '{2,1,'h05,4}, '{2,2,'h04,7}, '{2,3,'h0B,10}, '{2,4,'h14,12},
      '{2,5,'h14,13},
      '{3,1,'h07,5}, '{3,2,'h24,8}, '{3,3,'h1C,12}, '{3,4,'h13,13},
      '{4,1,'h06,5}, '{4,2,'h0F,10}, '{4,3,'h12,12},
      '{5,1,'h07,6}, '{5,2,'h09,10}, '{5,3,'h12,13},
      '{6,1,'h05,6}, '{6,2,'h1E,12}, '{7,1,'h04,6}, '{7,2,'h15,12},
      '{8,1,'h07,7}, '{8,2,'h11,12}, '{9,1,'h05,7}, '{9,2,'h11,13},
      '{10,1,'h27,8}, '{10,2,'h10,13}, '{11,1,'h23,8}, '{12,1,'h22,8},
      '{13,1,'h20,8}, '{14,1,'h0E,10}, '{15,1,'h0D,10}, '{16,1,'h08,10},
      '{17,1,'h1F,12}, '{18,1,'h1A,12}, '{19,1,'h19,12}, '{20,1,'h17,12},
      '{21,1,'h16,12}, '{22,1,'h1F,13}, '{23,1,'h1E,13}, '{24,1,'h1D,13},
      '{25,1,'h1C,13}, '{26,1,'h1B,13}};
    bits = 0;
    len = 0;
    foreach (tab[i])
      if (tab[i][0] == run && tab[i][1] == lev) begin
        bits = tab[i][2];
        len = tab[i][3];
      end
  endfunction

  task automatic predict_codes(input logic signed [11:0] coef, input int pos, input int q,
                               input int thr);
    int c, dc, mag, lv, amag, bits, len;
    logic [7:0] lev8;
    bit neg, lneg;
    code_word_t w;
    c = coef;
    if (pos == 0) begin
      dc = (c + 4) >>> 3;
      if (dc <= 0) dc = 1;
      else if (dc > 254) dc = 254;
      else if (dc == 128) dc = 255;
      run_len = '0;
      w = '{bits: 20'(dc), len: 5'd8, eob: 1'b0};
      word_q.push_back(w);
      return;
    end
    neg = c < 0;
    mag = neg ? -c : c;
    lv = (div_on && q != 0) ? mag / (2 * q) : mag;
    if (pos >= 20 && lv <= thr) lv = 0;
    lev8 = 8'(neg ? -lv : lv);
    if (lev8 == 0) begin
      run_len = run_len + 6'd1;
    end else begin
      lneg = lev8[7];
      amag = lneg ? 256 - lev8 : lev8;
      len = 0;
      if (amag <= 15) tcoeff_code(run_len, amag, bits, len);
      if (len != 0) begin
        bits = (bits << 1) | lneg;
        len = len + 1;
      end else begin
        bits = (1 << 14) | (int'(run_len) << 8) | lev8;
        len = 20;
      end
      w = '{bits: 20'(bits), len: 5'(len), eob: 1'b0};
      word_q.push_back(w);
      run_len = '0;
    end
    if (pos == 63) begin
      w = '{bits: 20'd2, len: 5'd2, eob: 1'b1};
      word_q.push_back(w);
      run_len = '0;
    end
  endtask

  always @(posedge clk) begin
    code_word_t e;
    if (!rst_n) begin
      div_on <= 1'b1;
      run_len = '0;
      word_q.delete();
      fail_count <= 0;
      words_seen <= 0;
      blocks_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) div_on <= cfg_divide_enable;
      if (in_valid && !in_stall)
        predict_codes(in_coefficient, in_scan_position, in_quantizer, in_filter_threshold);
      if (out_valid && !out_stall) begin
        words_seen <= words_seen + 1;
        if (out_block_end) blocks_seen <= blocks_seen + 1;
        if (word_q.size() == 0) begin
          $error("unexpected word bits=%h len=%0d", out_code_bits, out_code_length);
          fail_count <= fail_count + 1;
        end else begin
          e = word_q.pop_front();
          if (out_code_bits !== e.bits || out_code_length !== e.len ||
              out_block_end !== e.eob) begin
            if (out_code_bits !== e.bits)
              $error("code_bits expected %h actual %h", e.bits, out_code_bits);
            if (out_code_length !== e.len)
              $error("code_length expected %0d actual %0d", e.len, out_code_length);
            if (out_block_end !== e.eob)
              $error("block_end expected %0d actual %0d", e.eob, out_block_end);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_words = word_q.size();
  end
endmodule

// ===== verif/tb_top.sv =====
// top of the run-level coder testbench: clock, reset, stimulus and verdict
// depends on h261rl_pkg, h261_block_run_level_coder_top and h261rl_checker
`timescale 1ns / 1ps
module tb_top;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic [h261rl_pkg::CoefW-1:0] in_coefficient = '0;
  logic [h261rl_pkg::PosW-1:0] in_scan_position = '0;
  logic [h261rl_pkg::QuantW-1:0] in_quantizer = h261rl_pkg::QuantW'(1);
  logic [h261rl_pkg::ThrW-1:0] in_filter_threshold = '0;
  logic cfg_valid = 1'b0, cfg_ready, cfg_divide_enable = 1'b1;
  logic out_valid, out_stall = 1'b0;
  logic [h261rl_pkg::CodeW-1:0] out_code_bits;
  logic [h261rl_pkg::LenW-1:0] out_code_length;
  logic out_block_end;
  int fail_count, pending_words, words_seen, blocks_seen;
  int send_idle_pct = 0, recv_idle_pct = 0, hold_cycles = 0;
  bit hold_req = 1'b0, hold_taken = 1'b0;
  int items_sent = 0;
  longint cycle_count = 0;

  localparam longint CycleLimit = 400000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  h261_block_run_level_coder_top dut (.*);
  h261rl_checker chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall: random idling, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      out_stall <= 1'b1;
      hold_cycles <= 300;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_word(input logic [h261rl_pkg::CoefW-1:0] c, input int pos, input int q,
                           input int thr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coefficient <= c;
    in_scan_position <= h261rl_pkg::PosW'(pos);
    in_quantizer <= h261rl_pkg::QuantW'(q);
    in_filter_threshold <= h261rl_pkg::ThrW'(thr);
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_divide(input logic en);
    cfg_valid <= 1'b1;
    cfg_divide_enable <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one block: mostly small levels and zero runs, occasional wild values
  task automatic send_block(input int last_pos);
    int q, thr, r;
    logic [h261rl_pkg::CoefW-1:0] c;
    q = ($urandom_range(9) == 0) ? 31 : $urandom_range(1, 6);
    thr = $urandom_range(7);
    for (int p = 0; p <= last_pos; p++) begin
      r = $urandom_range(99);
      if (p == 0) c = h261rl_pkg::CoefW'($urandom);
      else if (r < 45) c = 0;
      else if (r < 85) c = h261rl_pkg::CoefW'($urandom_range(0, 8 * q) *
                                                ($urandom_range(1) ? 1 : -1));
      else c = h261rl_pkg::CoefW'($urandom);
      send_word(c, p, q, thr);
    end
  endtask

  initial begin
    int phase_items;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: dc extremes and rounding, sign extremes, escapes, filter, eob
    send_word(12'h000, 0, 1, 0);
    send_word(12'h7ff, 0, 1, 0);
    send_word(12'h800, 0, 1, 0);
    send_word(12'd1020, 0, 1, 0);
    send_word(12'd1021, 1, 1, 0);
    send_word(12'h800, 2, 1, 0);
    send_word(12'hffe, 3, 1, 0);
    send_word(12'd0, 4, 1, 0);
    send_word(12'd0, 5, 31, 7);
    send_word(12'd62, 6, 31, 0);
    send_word(12'h7ff, 7, 31, 0);
    send_word(12'd14, 20, 1, 7);
    send_word(12'd16, 21, 1, 7);
    send_word(12'h801, 62, 1, 0);
    send_word(12'd2, 63, 1, 0);
    send_word(12'd0, 63, 31, 7);
    drain();
    write_divide(1'b0);
    send_word(12'd256, 1, 31, 0);
    send_word(12'hf00, 2, 31, 0);
    send_word(12'hf80, 3, 5, 0);
    send_word(12'd5, 25, 5, 4);
    send_word(12'd3, 63, 0, 7);
    drain();
    write_divide(1'b1);
    send_word(12'd300, 1, 0, 0);
    send_word(12'hfff, 63, 1, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph % 3 == 0) ? 34 : (ph % 3 == 1) ? 64 : 0;
      recv_idle_pct = (ph % 3 == 0) ? 64 : (ph % 3 == 1) ? 34 : 0;
      if (ph == 2) hold_req = 1'b1;
      phase_items = items_sent + 240;
      while (items_sent < phase_items)
        send_block(($urandom_range(3) == 0) ? $urandom_range(1, 63) : 63);
      drain();
      write_divide(ph % 2 == 1);
    end
    write_divide(1'b1);

    $display("sent %0d coefficients, received %0d code words closing %0d blocks",
             items_sent, words_seen, blocks_seen);
    $display("covered both divide settings, random idling and a long output hold-off");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
